// ===== src/ngp_pkg.sv =====
// ----------------------------------------------------------------------------
// ngp_pkg
// Shared types and constants of the GGA sentence field parser.
// ----------------------------------------------------------------------------
package ngp_pkg;

	// result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// field codes
	localparam logic [2:0] FLD_TIME = 3'd0;
	localparam logic [2:0] FLD_LAT  = 3'd1;
	localparam logic [2:0] FLD_NS   = 3'd2;
	localparam logic [2:0] FLD_LON  = 3'd3;
	localparam logic [2:0] FLD_EW   = 3'd4;
	localparam logic [2:0] FLD_FIX  = 3'd5;
	localparam logic [2:0] FLD_SAT  = 3'd6;

	// parse phases
	localparam logic [3:0] PH_HUNT = 4'd0;
	localparam logic [3:0] PH_SKIP = 4'd1;
	localparam logic [3:0] PH_TIME = 4'd2;
	localparam logic [3:0] PH_LAT  = 4'd3;
	localparam logic [3:0] PH_LON  = 4'd5;
	localparam logic [3:0] PH_SAT  = 4'd8;

	// characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_A      = 8'h41;

	localparam int unsigned HDR_LEN = 6;
	localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A};

	// one result item
	typedef struct packed {
		logic       kind;
		logic [2:0] field_code;
		logic [3:0] char_pos;
		logic [7:0] char_value;
	} result_t;

endpackage

// ===== src/ngp_if.sv =====
// ----------------------------------------------------------------------------
// ngp_in_if / ngp_out_if
// Valid/ready channels for received bytes and tagged result items.
// ----------------------------------------------------------------------------
interface ngp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ngp_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [2:0] field_code;
	logic [3:0] char_pos;
	logic [7:0] char_value;

	modport source (output valid, output kind, output field_code, output char_pos,
		output char_value, input ready);
	modport sink   (input valid, input kind, input field_code, input char_pos,
		input char_value, output ready);
endinterface

// ===== src/ngp_tagger.sv =====
// ----------------------------------------------------------------------------
// ngp_tagger
// Header hunt and field tagging state; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module ngp_tagger #(
	parameter int FIELD_CHARS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	output ngp_pkg::result_t  res
);

	localparam int IW = $clog2(FIELD_CHARS + 1);

	logic [3:0]    phase_q, phase_d;
	logic [2:0]    hdr_q, hdr_d;
	logic [IW-1:0] idx_q, idx_d;

	logic [2:0]    m;
	logic          multi;
	logic [IW+3:0] idx_ext;

	assign idx_ext = {4'b0, idx_q};
	assign m       = (hdr_q > 3'd5) ? 3'd0 : hdr_q;
	assign multi   = (phase_q == ngp_pkg::PH_TIME) || (phase_q == ngp_pkg::PH_LAT) ||
		(phase_q == ngp_pkg::PH_LON);

	// next state and result
	always_comb begin
		phase_d   = phase_q;
		hdr_d     = hdr_q;
		idx_d     = idx_q;
		res_valid = 1'b0;
		res       = '0;
		res.kind  = ngp_pkg::KIND_CHAR;
		res.field_code = 3'(phase_q - ngp_pkg::PH_TIME);
		res.char_value = rx_byte;
		priority if (phase_q == ngp_pkg::PH_SKIP) begin
			if (rx_byte == ngp_pkg::CH_COMMA) begin
				phase_d = ngp_pkg::PH_TIME;
				idx_d   = '0;
			end
		end else if (phase_q >= ngp_pkg::PH_TIME && phase_q <= ngp_pkg::PH_SAT) begin
			if (rx_byte == ngp_pkg::CH_COMMA) begin
				idx_d = '0;
				if (phase_q == ngp_pkg::PH_SAT) begin
					phase_d   = ngp_pkg::PH_HUNT;
					hdr_d     = '0;
					res_valid = 1'b1;
					res       = '0;
					res.kind  = ngp_pkg::KIND_DONE;
				end else begin
					phase_d = phase_q + 4'd1;
				end
			end else if (multi) begin
				// drop characters past the field capacity
				if (idx_q < IW'(FIELD_CHARS)) begin
					res_valid    = 1'b1;
					res.char_pos = idx_ext[3:0];
					idx_d        = idx_q + 1'b1;
				end
			end else begin
				res_valid = 1'b1;
			end
		end else begin
			// hunting; unused phases behave the same
			phase_d = ngp_pkg::PH_HUNT;
			if (rx_byte == ngp_pkg::HDR_TEXT[m]) begin
				if (m == 3'd5) begin
					hdr_d   = '0;
					phase_d = ngp_pkg::PH_SKIP;
					idx_d   = '0;
				end else begin
					hdr_d = m + 3'd1;
				end
			end else if (rx_byte == ngp_pkg::CH_DOLLAR) begin
				hdr_d = 3'd1;
			end else begin
				hdr_d = '0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ngp_pkg::PH_HUNT;
			hdr_q   <= '0;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// ===== src/nmea_gga_field_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_field_parser
// Tags the characters of GGA sentence fields in a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : valid/ready channel of received bytes (rx_byte), one item per byte.
//   res : valid/ready channel of tagged items (kind, field_code, char_pos,
//         char_value). A byte gives zero or one result item.
// Each accepted byte lands in an input register. Once the output register
// is free, the tagger state updates and any result is written to the
// output register. Throughput is one byte per cycle while res does not
// stall; the tagger state update lies between the input and output
// registers.
// When res stalls, the output register holds its item and the input
// register still takes one more byte; rx.ready then drops until the output
// frees up. Bytes that give no result also wait for a free output slot.
// Reset clears both valid flags and returns the tagger to header hunting.
// ----------------------------------------------------------------------------
module nmea_gga_field_parser #(
	parameter int FIELD_CHARS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	ngp_in_if.sink           rx,
	ngp_out_if.source        res
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_free;
	logic             advance;
	logic             tag_valid;
	ngp_pkg::result_t tag_res;
	logic             valid_q;
	ngp_pkg::result_t res_q;

	assign out_free = !valid_q || res.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	ngp_tagger #(
		.FIELD_CHARS(FIELD_CHARS)
	) u_tagger (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.res_valid (tag_valid),
		.res       (tag_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= advance && tag_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tag_valid) begin
			res_q <= tag_res;
		end
	end

	assign res.valid      = valid_q;
	assign res.kind       = res_q.kind;
	assign res.field_code = res_q.field_code;
	assign res.char_pos   = res_q.char_pos;
	assign res.char_value = res_q.char_value;

endmodule
